// ----- rtl/core/xmb_pkg.sv -----
// ----------------------------------------------------------------------------
// XMODEM block receiver package
// Shared codes, result type and the CRC-16/XMODEM byte update.
// ----------------------------------------------------------------------------
package xmb_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_C   = 8'h43;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_REPLY  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_RUNNING  = 2'd0;
    localparam logic [1:0] ST_FINISHED = 2'd1;
    localparam logic [1:0] ST_FAILED   = 2'd2;

    localparam logic CFG_CRC_MODE = 1'b0;
    localparam logic CFG_TIMEOUT  = 1'b1;

    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
    localparam int          DATA_INDEX_W   = 7;

    typedef struct packed {
        logic [1:0]              kind;
        logic [7:0]              data;
        logic [DATA_INDEX_W-1:0] index;
        logic                    commit;
        logic [1:0]              status;
    } t_result;

    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/xmb_in_if.sv -----
// ----------------------------------------------------------------------------
// XMODEM receiver input channel
// Carries one operation request and its received byte.
// ----------------------------------------------------------------------------
interface xmb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

// ----- rtl/core/xmb_out_if.sv -----
// ----------------------------------------------------------------------------
// XMODEM receiver result channel
// Carries one result request: data byte, reply byte or status.
// ----------------------------------------------------------------------------
interface xmb_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic [6:0] data_index;
    logic       commit;
    logic [1:0] status;

    modport source (output valid, output result_kind, output out_byte, output data_index,
                    output commit, output status, input ready);
    modport sink   (input valid, input result_kind, input out_byte, input data_index,
                    input commit, input status, output ready);
endinterface

// ----- rtl/core/xmb_cfg_if.sv -----
// ----------------------------------------------------------------------------
// XMODEM receiver configuration channel
// Carries one register write request: index and data.
// ----------------------------------------------------------------------------
interface xmb_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/xmodem_block_receiver.sv -----
// ----------------------------------------------------------------------------
// XMODEM block receiver
// Takes the sender's bytes, start requests and timer ticks, and answers as an
// XMODEM receiver: data bytes out, ACK, NAK or C replies, and status.
// ----------------------------------------------------------------------------
// The block accepts one request per clock cycle while the result side is not
// stalled. A request is held in the input register, where the protocol step
// decodes it against the transfer state, and its result, if any, is loaded
// into the result register and shown from there. Input ready falls only when
// the input register holds a request while the result register still waits
// to be taken. Configuration writes are taken in any cycle.
module xmodem_block_receiver #(
    parameter int BLOCK_BYTES = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    xmb_in_if.sink    i_in,
    xmb_cfg_if.sink   i_cfg,
    xmb_out_if.source o_out
);
    import xmb_pkg::*;

    logic        r_in_valid;
    logic [1:0]  r_op;
    logic [7:0]  r_byte;
    logic        r_crc_mode;
    logic [15:0] r_timeout;

    logic        fire;
    logic        out_busy;
    logic        res_valid;
    t_result     res;

    assign fire       = r_in_valid && !out_busy;
    assign i_in.ready = !r_in_valid || fire;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_op   <= i_in.operation;
            r_byte <= i_in.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_mode <= 1'b1;
            r_timeout  <= TIMEOUT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_CRC_MODE: r_crc_mode <= i_cfg.data[0];
                CFG_TIMEOUT:  r_timeout  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    xmb_step #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_op           (r_op),
        .i_byte         (r_byte),
        .i_crc_mode     (r_crc_mode),
        .i_timeout_ticks(r_timeout),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    xmb_out_reg u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (fire && res_valid),
        .i_res  (res),
        .o_busy (out_busy),
        .o_out  (o_out)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !fire)
        else $error("request decoded while a result was still waiting");

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_busy) |=> (r_in_valid && $stable(r_op) && $stable(r_byte)))
        else $error("held request lost while the result channel stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("input refused with an empty input register");

endmodule

// ----- rtl/core/xmb_step.sv -----
// ----------------------------------------------------------------------------
// XMODEM receiver protocol step
// Holds the transfer state and combinationally works out the next state and
// result of one registered request.
// ----------------------------------------------------------------------------
module xmb_step #(
    parameter int BLOCK_BYTES = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [1:0]        i_op,
    input  logic [7:0]        i_byte,
    input  logic              i_crc_mode,
    input  logic [15:0]       i_timeout_ticks,
    output logic              o_res_valid,
    output xmb_pkg::t_result  o_res
);
    import xmb_pkg::*;

    localparam int CW = $clog2(BLOCK_BYTES);
    localparam logic [CW-1:0] LAST = CW'(BLOCK_BYTES - 1);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEAD   = 3'd1;
    localparam logic [2:0] PH_NUM    = 3'd2;
    localparam logic [2:0] PH_CMP    = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_CHECK  = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;
    localparam logic [2:0] PH_FAILED = 3'd7;

    logic [2:0]    r_phase,    n_phase;
    logic [7:0]    r_expected, n_expected;
    logic          r_hdr_good, n_hdr_good;
    logic [CW-1:0] r_count,    n_count;
    logic          r_second,   n_second;
    logic [15:0]   r_crc,      n_crc;
    logic [7:0]    r_sum,      n_sum;
    logic [7:0]    r_first,    n_first;
    logic [15:0]   r_idle,     n_idle;

    logic          running;
    logic [15:0]   idle_inc;
    logic          check_ok;

    assign running  = (r_phase >= PH_HEAD) && (r_phase <= PH_CHECK);
    assign idle_inc = r_idle + 16'd1;

    always_comb begin
        n_phase     = r_phase;
        n_expected  = r_expected;
        n_hdr_good  = r_hdr_good;
        n_count     = r_count;
        n_second    = r_second;
        n_crc       = r_crc;
        n_sum       = r_sum;
        n_first     = r_first;
        n_idle      = r_idle;
        o_res_valid = 1'b0;
        o_res       = '0;
        check_ok    = 1'b0;
        unique case (i_op)
            OP_START: begin
                n_phase     = PH_HEAD;
                n_expected  = 8'd1;
                n_hdr_good  = 1'b0;
                n_count     = '0;
                n_second    = 1'b0;
                n_crc       = '0;
                n_sum       = '0;
                n_first     = '0;
                n_idle      = '0;
                o_res_valid = 1'b1;
                o_res.kind  = KIND_REPLY;
                o_res.data  = i_crc_mode ? CH_C : CH_NAK;
            end
            OP_TICK: begin
                if (running) begin
                    n_idle = idle_inc;
                    if (idle_inc >= i_timeout_ticks) begin
                        n_phase     = PH_FAILED;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_STATUS;
                    end
                end
            end
            OP_BYTE: begin
                if (running) begin
                    n_idle = '0;
                    unique case (r_phase)
                        PH_HEAD: begin
                            if (i_byte == CH_SOH) begin
                                n_phase    = PH_NUM;
                                n_hdr_good = 1'b1;
                                n_crc      = '0;
                                n_sum      = '0;
                                n_count    = '0;
                            end else if (i_byte == CH_EOT) begin
                                n_phase     = PH_DONE;
                                o_res_valid = 1'b1;
                                o_res.kind  = KIND_REPLY;
                                o_res.data  = CH_ACK;
                            end
                        end
                        PH_NUM: begin
                            if (i_byte != r_expected) begin
                                n_hdr_good = 1'b0;
                            end
                            n_phase = PH_CMP;
                        end
                        PH_CMP: begin
                            if (i_byte != ~r_expected) begin
                                n_hdr_good = 1'b0;
                            end
                            n_phase = PH_DATA;
                            n_count = '0;
                        end
                        PH_DATA: begin
                            n_crc       = crc_add(r_crc, i_byte);
                            n_sum       = r_sum + i_byte;
                            o_res_valid = 1'b1;
                            o_res.kind  = KIND_DATA;
                            o_res.data  = i_byte;
                            o_res.index = r_count[DATA_INDEX_W-1:0];
                            if (r_count == LAST) begin
                                n_phase  = PH_CHECK;
                                n_count  = '0;
                                n_second = 1'b0;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        PH_CHECK: begin
                            if (!i_crc_mode || r_second) begin
                                if (!i_crc_mode) begin
                                    check_ok = (i_byte == r_sum);
                                end else begin
                                    check_ok = (r_first == r_crc[15:8]) &&
                                               (i_byte == r_crc[7:0]);
                                end
                                n_second    = 1'b0;
                                n_phase     = PH_HEAD;
                                o_res_valid = 1'b1;
                                o_res.kind  = KIND_REPLY;
                                if (check_ok && r_hdr_good) begin
                                    n_expected   = r_expected + 8'd1;
                                    o_res.data   = CH_ACK;
                                    o_res.commit = 1'b1;
                                end else begin
                                    o_res.data = CH_NAK;
                                end
                            end else begin
                                n_first  = i_byte;
                                n_second = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
        if (n_phase == PH_DONE) begin
            o_res.status = ST_FINISHED;
        end else if (n_phase == PH_FAILED) begin
            o_res.status = ST_FAILED;
        end else begin
            o_res.status = ST_RUNNING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_expected <= 8'd1;
            r_hdr_good <= 1'b0;
            r_count    <= '0;
            r_second   <= 1'b0;
            r_crc      <= '0;
            r_sum      <= '0;
            r_first    <= '0;
            r_idle     <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_expected <= n_expected;
            r_hdr_good <= n_hdr_good;
            r_count    <= n_count;
            r_second   <= n_second;
            r_crc      <= n_crc;
            r_sum      <= n_sum;
            r_first    <= n_first;
            r_idle     <= n_idle;
        end
    end

    a_data_in_data_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_DATA) |-> (r_phase == PH_DATA))
        else $error("data byte produced outside the data phase");

    a_commit_is_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.commit) |-> (o_res.kind == KIND_REPLY && o_res.data == CH_ACK))
        else $error("commit raised on something other than an ACK reply");

    a_last_byte_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_op == OP_BYTE && r_phase == PH_DATA && r_count == LAST)
        |=> (r_phase == PH_CHECK && r_count == '0))
        else $error("last data byte did not move to the check bytes");

    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_op == OP_START) |=> (r_phase == PH_HEAD && r_expected == 8'd1))
        else $error("start request did not restart the transfer");

endmodule

// ----- rtl/core/xmb_out_reg.sv -----
// ----------------------------------------------------------------------------
// XMODEM receiver result register
// Holds one finished result until the result channel takes it.
// ----------------------------------------------------------------------------
module xmb_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  xmb_pkg::t_result i_res,
    output logic             o_busy,
    xmb_out_if.source        o_out
);
    import xmb_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_busy = r_valid && !o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.result_kind = r_res.kind;
    assign o_out.out_byte    = r_res.data;
    assign o_out.data_index  = r_res.index;
    assign o_out.commit      = r_res.commit;
    assign o_out.status      = r_res.status;

endmodule

// ----- tb/xmodem_block_receiver_test.sv -----
// ----------------------------------------------------------------------------
// XMODEM block receiver testbench
// Drives start, byte and tick requests into the receiver and checks every
// data byte, reply byte and status request that comes back against a
// cycle-free model of the protocol kept here. Directed cases come first, then
// a mid-block mode change, randomised block traffic under several register
// settings and idling patterns, and a long stall of the result side.
// ----------------------------------------------------------------------------
module xmodem_block_receiver_test;
    import xmb_pkg::*;

    localparam int         BLOCK_LEN  = 128;
    localparam logic [1:0] OP_SPARE   = 2'd3;
    localparam int         HOLD_CYCLES = 400;

    typedef enum logic [2:0] {
        XFER_IDLE,
        XFER_HEAD,
        XFER_NUMBER,
        XFER_COMPLEMENT,
        XFER_DATA,
        XFER_CHECK,
        XFER_DONE,
        XFER_FAILED
    } xfer_phase_e;

    logic i_clk;
    logic i_rst_n;

    xmb_in_if  feed ();
    xmb_cfg_if regs ();
    xmb_out_if answer ();

    xmodem_block_receiver #(
        .BLOCK_BYTES (BLOCK_LEN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (feed),
        .i_cfg   (regs),
        .o_out   (answer)
    );

    // Register copies and transfer state of the receiver model.
    logic        cfg_crc;
    logic [15:0] cfg_timeout;
    xfer_phase_e st_phase;
    logic [7:0]  st_block;
    logic        st_header_ok;
    logic [15:0] st_count;
    logic [15:0] st_crc;
    logic [7:0]  st_sum;
    logic [7:0]  st_check_hi;
    logic [15:0] st_ticks;

    t_result awaited_results [$];
    int      requests_counted;
    int      mismatches;
    int      send_gap_pct;
    int      recv_gap_pct;
    logic    hold_req;
    int      hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic bit transfer_running();
        return st_phase >= XFER_HEAD && st_phase <= XFER_CHECK;
    endfunction

    function automatic void reset_model();
        cfg_crc      = 1'b1;
        cfg_timeout  = TIMEOUT_RESET;
        st_phase     = XFER_IDLE;
        st_block     = 8'd1;
        st_header_ok = 1'b0;
        st_count     = '0;
        st_crc       = '0;
        st_sum       = '0;
        st_check_hi  = '0;
        st_ticks     = '0;
    endfunction

    // Works out the result, if any, of one accepted request and queues it.
    function automatic void predict_receiver_reply(input logic [1:0] op, input logic [7:0] b);
        t_result r;
        bit      has_result;
        bit      block_over;
        bit      check_ok;
        r          = '0;
        has_result = 0;
        block_over = 0;
        check_ok   = 0;
        if (op == OP_START || (op != OP_SPARE && transfer_running())) begin
            requests_counted++;
        end
        if (op == OP_START) begin
            st_phase     = XFER_HEAD;
            st_block     = 8'd1;
            st_header_ok = 1'b0;
            st_count     = '0;
            st_crc       = '0;
            st_sum       = '0;
            st_check_hi  = '0;
            st_ticks     = '0;
            r.kind       = KIND_REPLY;
            r.data       = cfg_crc ? CH_C : CH_NAK;
            has_result   = 1;
        end else if (op == OP_TICK) begin
            if (transfer_running()) begin
                st_ticks = st_ticks + 16'd1;
                if (st_ticks >= cfg_timeout) begin
                    st_phase   = XFER_FAILED;
                    r.kind     = KIND_STATUS;
                    has_result = 1;
                end
            end
        end else if (op == OP_BYTE && transfer_running()) begin
            st_ticks = '0;
            case (st_phase)
                XFER_HEAD: begin
                    if (b == CH_SOH) begin
                        st_phase     = XFER_NUMBER;
                        st_header_ok = 1'b1;
                        st_crc       = '0;
                        st_sum       = '0;
                        st_count     = '0;
                    end else if (b == CH_EOT) begin
                        st_phase   = XFER_DONE;
                        r.kind     = KIND_REPLY;
                        r.data     = CH_ACK;
                        has_result = 1;
                    end
                end
                XFER_NUMBER: begin
                    if (b != st_block) begin
                        st_header_ok = 1'b0;
                    end
                    st_phase = XFER_COMPLEMENT;
                end
                XFER_COMPLEMENT: begin
                    if (b != ~st_block) begin
                        st_header_ok = 1'b0;
                    end
                    st_phase = XFER_DATA;
                    st_count = '0;
                end
                XFER_DATA: begin
                    r.kind     = KIND_DATA;
                    r.data     = b;
                    r.index    = st_count[DATA_INDEX_W-1:0];
                    has_result = 1;
                    st_crc     = crc16_next(st_crc, b);
                    st_sum     = st_sum + b;
                    st_count   = st_count + 16'd1;
                    if (st_count >= BLOCK_LEN) begin
                        st_phase = XFER_CHECK;
                        st_count = '0;
                    end
                end
                default: begin
                    if (!cfg_crc) begin
                        block_over = 1;
                        check_ok   = (b == st_sum);
                    end else if (st_count == 0) begin
                        st_check_hi = b;
                        st_count    = 16'd1;
                    end else begin
                        st_count   = '0;
                        block_over = 1;
                        check_ok   = (st_check_hi == st_crc[15:8]) && (b == st_crc[7:0]);
                    end
                end
            endcase
        end
        if (block_over) begin
            st_phase   = XFER_HEAD;
            r.kind     = KIND_REPLY;
            has_result = 1;
            if (check_ok && st_header_ok) begin
                st_block = st_block + 8'd1;
                r.data   = CH_ACK;
                r.commit = 1'b1;
            end else begin
                r.data = CH_NAK;
            end
        end
        if (has_result) begin
            r.status = (st_phase == XFER_DONE)   ? ST_FINISHED :
                       (st_phase == XFER_FAILED) ? ST_FAILED : ST_RUNNING;
            awaited_results.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 100) begin
            $display("mismatch at %0t: %s, got %0h, expected %0h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    // The valid line is left high after a request is taken, so the caller
    // either sends the next request in the same step or settles the block.
    task automatic send_request(input logic [1:0] op, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            feed.valid <= 1'b0;
            @(posedge i_clk);
        end
        feed.valid     <= 1'b1;
        feed.operation <= op;
        feed.rx_byte   <= b;
        do @(posedge i_clk); while (!feed.ready);
        predict_receiver_reply(op, b);
    endtask

    task automatic settle_receiver();
        feed.valid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        regs.valid <= 1'b1;
        regs.index <= idx;
        regs.data  <= value;
        do @(posedge i_clk); while (!regs.ready);
        if (idx == CFG_CRC_MODE) begin
            cfg_crc = value[0];
        end else begin
            cfg_timeout = value;
        end
        regs.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_data_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return CH_SOH;
            3:       return CH_EOT;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_block(input logic [7:0] num, input logic [7:0] num_inv,
                              input bit spoil, input bit flip_mode, input int tick_pct);
        logic [15:0] crc;
        logic [7:0]  sum;
        logic [7:0]  b;
        logic [15:0] flaw;
        crc = '0;
        sum = '0;
        send_request(OP_BYTE, CH_SOH);
        send_request(OP_BYTE, num);
        send_request(OP_BYTE, num_inv);
        for (int i = 0; i < BLOCK_LEN; i++) begin
            b   = pick_data_byte();
            crc = crc16_next(crc, b);
            sum = sum + b;
            send_request(OP_BYTE, b);
            if ($urandom_range(0, 99) < tick_pct) begin
                send_request(OP_TICK, 8'($urandom));
            end
        end
        if (flip_mode) begin
            settle_receiver();
            write_reg(CFG_CRC_MODE, {15'd0, ~cfg_crc});
        end
        flaw = spoil ? (16'd1 << $urandom_range(0, 15)) : 16'd0;
        if (cfg_crc) begin
            crc = crc ^ flaw;
            send_request(OP_BYTE, crc[15:8]);
            send_request(OP_BYTE, crc[7:0]);
        end else begin
            send_request(OP_BYTE, sum ^ (spoil ? (8'd1 << $urandom_range(0, 7)) : 8'd0));
        end
    endtask

    task automatic test_directed();
        send_request(OP_BYTE, CH_SOH);
        send_request(OP_TICK, 8'h00);
        send_request(OP_SPARE, 8'hFF);
        send_request(OP_START, 8'hFF);
        send_request(OP_BYTE, 8'h00);
        send_request(OP_BYTE, 8'hFF);
        send_request(OP_SPARE, 8'h00);
        send_request(OP_TICK, 8'hA5);
        send_request(OP_BYTE, CH_EOT);
        send_request(OP_BYTE, 8'hAA);
        send_request(OP_TICK, 8'h5A);
        send_request(OP_START, 8'h00);
        send_request(OP_START, 8'h81);
        settle_receiver();
        write_reg(CFG_CRC_MODE, 16'd0);
        write_reg(CFG_TIMEOUT, 16'd0);
        send_request(OP_START, 8'h00);
        send_request(OP_TICK, 8'h00);
        send_request(OP_BYTE, CH_SOH);
        send_request(OP_TICK, 8'h00);
        settle_receiver();
        write_reg(CFG_TIMEOUT, 16'd2);
        send_request(OP_START, 8'h00);
        send_request(OP_TICK, 8'h00);
        send_request(OP_BYTE, 8'h55);
        send_request(OP_TICK, 8'h00);
        send_request(OP_TICK, 8'h00);
        settle_receiver();
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        write_reg(CFG_CRC_MODE, 16'd1);
        send_request(OP_START, 8'h7E);
    endtask

    task automatic test_mode_switch();
        settle_receiver();
        write_reg(CFG_CRC_MODE, 16'd1);
        send_request(OP_START, 8'h00);
        send_block(st_block, ~st_block, 0, 1, 0);
        send_block(st_block, ~st_block, 0, 1, 0);
        send_block(st_block, ~st_block, 1, 1, 0);
        settle_receiver();
    endtask

    task automatic run_random_action();
        int          pick;
        logic [7:0]  num;
        logic [7:0]  num_inv;
        pick = $urandom_range(0, 99);
        if (!transfer_running()) begin
            if (pick < 80) begin
                send_request(OP_START, 8'($urandom));
            end else begin
                send_request(2'($urandom_range(1, 3)), 8'($urandom));
            end
        end else if (pick < 60) begin
            num = st_block;
            case ($urandom_range(0, 49))
                0, 1, 2, 3: num = st_block - 8'd1;
                4, 5, 6:    num = 8'($urandom);
                default:    num = st_block;
            endcase
            num_inv = ($urandom_range(0, 99) < 8) ? 8'($urandom) : ~num;
            send_block(num, num_inv, $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 4, 2);
        end else if (pick < 70) begin
            repeat ($urandom_range(1, 3)) send_request(OP_BYTE, 8'($urandom));
        end else if (pick < 80) begin
            repeat ($urandom_range(1, 4)) send_request(OP_TICK, 8'($urandom));
        end else if (pick < 85) begin
            send_request(OP_BYTE, CH_EOT);
        end else if (pick < 90) begin
            send_request(OP_START, 8'($urandom));
        end else if (pick < 95) begin
            send_request(OP_BYTE, CH_SOH);
            send_request(OP_BYTE, st_block);
            send_request(OP_BYTE, ~st_block);
            repeat ($urandom_range(0, 20)) send_request(OP_BYTE, pick_data_byte());
            if ($urandom_range(0, 1) == 1) begin
                send_request(OP_START, 8'($urandom));
            end
        end else begin
            send_request(OP_SPARE, 8'($urandom));
        end
    endtask

    task automatic test_random_traffic(input int quota);
        int          goal;
        int          session_end;
        int          session;
        logic [15:0] limit;
        goal    = requests_counted + quota;
        session = 0;
        while (requests_counted < goal) begin
            case (session % 4)
                0:       limit = 16'hFFFF;
                1:       limit = 16'd1;
                2:       limit = 16'($urandom_range(2, 12));
                default: limit = 16'($urandom_range(13, 65535));
            endcase
            settle_receiver();
            write_reg(CFG_CRC_MODE, (session % 4 == 0) ? 16'd1 :
                                    (session % 4 == 1) ? 16'd0 : 16'($urandom_range(0, 1)));
            write_reg(CFG_TIMEOUT, limit);
            send_request(OP_START, 8'($urandom));
            session_end = requests_counted + $urandom_range(150, 400);
            while (requests_counted < session_end && requests_counted < goal) begin
                run_random_action();
            end
            session++;
        end
        settle_receiver();
    endtask

    task automatic test_backpressure();
        int keep_gap;
        keep_gap     = send_gap_pct;
        send_gap_pct = 0;
        settle_receiver();
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        send_request(OP_START, 8'h00);
        send_block(st_block, ~st_block, 0, 0, 0);
        send_block(st_block, ~st_block, 0, 0, 0);
        settle_receiver();
        send_gap_pct = keep_gap;
    endtask

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left    <= HOLD_CYCLES;
            answer.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            answer.ready <= 1'b0;
        end else begin
            answer.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && answer.valid && answer.ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing awaited", answer.result_kind, 0);
            end else begin
                want = awaited_results.pop_front();
                if (answer.result_kind !== want.kind) begin
                    report_mismatch("result_kind", answer.result_kind, want.kind);
                end
                if (answer.out_byte !== want.data) begin
                    report_mismatch("out_byte", answer.out_byte, want.data);
                end
                if (answer.data_index !== want.index) begin
                    report_mismatch("data_index", answer.data_index, want.index);
                end
                if (answer.commit !== want.commit) begin
                    report_mismatch("commit", answer.commit, want.commit);
                end
                if (answer.status !== want.status) begin
                    report_mismatch("status", answer.status, want.status);
                end
            end
        end
    end

    initial begin
        int waited;
        i_rst_n          = 1'b0;
        feed.valid       = 1'b0;
        feed.operation   = OP_TICK;
        feed.rx_byte     = 8'h00;
        regs.valid       = 1'b0;
        regs.index       = CFG_CRC_MODE;
        regs.data        = 16'd0;
        hold_req         = 1'b0;
        requests_counted = 0;
        mismatches       = 0;
        send_gap_pct     = 29;
        recv_gap_pct     = 49;
        reset_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_mode_switch();
        test_random_traffic(300);

        send_gap_pct = 49;
        recv_gap_pct = 29;
        test_random_traffic(300);
        test_backpressure();

        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_random_traffic(300);

        feed.valid <= 1'b0;
        waited = 0;
        while (awaited_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (awaited_results.size() != 0) begin
            report_mismatch("results never delivered", 0, awaited_results.size());
        end
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
